/* sv/sdca_pkg.sv */
`timescale 1ns / 1ps
// Package for the seven-channel decay accumulator: widths, constants and the
// per-channel update functions. No dependencies.
package sdca_pkg;

  localparam int unsigned NumChannels = 7;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned SumW        = 11;   // holds 7 * 255 + 3
  localparam int unsigned ProdW       = 16;   // holds 255 * 250 + 128

  localparam logic [ChanW-1:0]  ReportOnly = 3'd7;
  localparam logic [LevelW-1:0] LevelMax   = 8'd255;
  localparam logic [LevelW-1:0] DecayMul   = 8'd250;
  localparam logic [ProdW-1:0]  DecayRound = 16'd128;
  localparam logic [SumW-1:0]   MeanBias   = 11'd3;

  // Division by seven: multiply by ceil(2^14 / 7) and shift. Exact for all
  // dividends below 5461, well above the largest biased sum of 1788.
  localparam int unsigned MeanShift = 14;
  localparam int unsigned RecipW    = 12;
  localparam logic [RecipW-1:0] MeanRecip = 12'd2341;
  localparam int unsigned MeanProdW = SumW + RecipW;

  typedef logic [LevelW-1:0] level_t;
  typedef level_t [NumChannels-1:0] level_vec_t;

  function automatic level_t decay_level(input level_t v);
    logic [ProdW-1:0] t;
    t = ProdW'(v) * ProdW'(DecayMul) + DecayRound;
    return t[ProdW-1:LevelW];
  endfunction

  function automatic level_t sat_add(input level_t a, input level_t b);
    logic [LevelW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LevelW] ? LevelMax : s[LevelW-1:0];
  endfunction

endpackage

/* sv/sdca_in_if.sv */
`timescale 1ns / 1ps
// Channel interfaces for the decay accumulator: event input and result output.
// Depends on sdca_pkg.
interface sdca_in_if
  import sdca_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] channel;
  level_t           intensity;

  modport source (output valid, output channel, output intensity, input ready);
  modport sink   (input valid, input channel, input intensity, output ready);
endinterface

interface sdca_out_if
  import sdca_pkg::*;
  ();
  logic             valid;
  logic             ready;
  level_t           level_0;
  level_t           level_1;
  level_t           level_2;
  level_t           level_3;
  level_t           level_4;
  level_t           level_5;
  level_t           level_6;
  logic [ChanW-1:0] strongest;
  level_t           mean_level;

  modport source (output valid, output level_0, output level_1, output level_2,
                  output level_3, output level_4, output level_5, output level_6,
                  output strongest, output mean_level, input ready);
  modport sink   (input valid, input level_0, input level_1, input level_2,
                  input level_3, input level_4, input level_5, input level_6,
                  input strongest, input mean_level, output ready);
endinterface

/* sv/seven_channel_decay_accumulator_unit.sv */
`timescale 1ns / 1ps
// Top level of the seven-channel decay accumulator.
// Depends on sdca_pkg and the channel interfaces in sdca_in_if.sv.
//
//   channel   direction  payload
//   in_evt    sink       channel (3), intensity (8)
//   out_res   source     level_0..level_6 (8 each), strongest (3), mean_level (8)
//
// An accepted item updates the level registers in the same edge; the first
// stage then derives the strongest channel and the mean from those registers
// and loads them into the output register when it is free. One item per
// cycle is sustained while the output is ready. Reset clears all levels to
// zero and empties both stages. A stalled output holds its item, and the
// input stage stalls only while it is full and cannot move forward.
module seven_channel_decay_accumulator_unit
  import sdca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sdca_in_if.sink    in_evt,
  sdca_out_if.source out_res
);

  level_vec_t levels_r, levels_nxt;
  logic       s1_valid_r;
  logic       out_valid_r;
  level_vec_t out_levels_r;
  logic [ChanW-1:0] out_strongest_r;
  level_t     out_mean_r;

  logic in_fire, s1_adv;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_evt.ready = !s1_valid_r || s1_adv;
  assign in_fire      = in_evt.valid && in_evt.ready;

  // Level update: named channel adds, others decay; ReportOnly changes none.
  always_comb begin
    levels_nxt = levels_r;
    if (in_evt.channel != ReportOnly) begin
      for (int i = 0; i < NumChannels; i++) begin
        if (in_evt.channel == ChanW'(i)) begin
          levels_nxt[i] = sat_add(levels_r[i], in_evt.intensity);
        end else begin
          levels_nxt[i] = decay_level(levels_r[i]);
        end
      end
    end
  end

  // While the first stage holds an item, levels_r is that item's levels:
  // the registers cannot change again until the item moves on.
  level_t           max01, max23, max45, max03, max46;
  logic [ChanW-1:0] idx01, idx23, idx45, idx03, idx46, idx_all;
  logic [SumW-1:0]  sum_b;
  logic [MeanProdW-1:0] mean_prod;

  // Pairwise tree; the left side always has the lower indexes, so ties go left.
  always_comb begin
    if (levels_r[1] > levels_r[0]) begin
      max01 = levels_r[1]; idx01 = 3'd1;
    end else begin
      max01 = levels_r[0]; idx01 = 3'd0;
    end
    if (levels_r[3] > levels_r[2]) begin
      max23 = levels_r[3]; idx23 = 3'd3;
    end else begin
      max23 = levels_r[2]; idx23 = 3'd2;
    end
    if (levels_r[5] > levels_r[4]) begin
      max45 = levels_r[5]; idx45 = 3'd5;
    end else begin
      max45 = levels_r[4]; idx45 = 3'd4;
    end
    if (max23 > max01) begin
      max03 = max23; idx03 = idx23;
    end else begin
      max03 = max01; idx03 = idx01;
    end
    if (levels_r[6] > max45) begin
      max46 = levels_r[6]; idx46 = 3'd6;
    end else begin
      max46 = max45; idx46 = idx45;
    end
    if (max46 > max03) begin
      idx_all = idx46;
    end else begin
      idx_all = idx03;
    end
  end

  always_comb begin
    sum_b = MeanBias;
    for (int i = 0; i < NumChannels; i++) begin
      sum_b = sum_b + SumW'(levels_r[i]);
    end
    mean_prod = MeanProdW'(sum_b) * MeanProdW'(MeanRecip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        levels_r <= levels_nxt;
      end
      if (in_evt.ready) begin
        s1_valid_r <= in_evt.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_levels_r    <= levels_r;
      out_strongest_r <= idx_all;
      out_mean_r      <= mean_prod[MeanShift +: LevelW];
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.level_0    = out_levels_r[0];
  assign out_res.level_1    = out_levels_r[1];
  assign out_res.level_2    = out_levels_r[2];
  assign out_res.level_3    = out_levels_r[3];
  assign out_res.level_4    = out_levels_r[4];
  assign out_res.level_5    = out_levels_r[5];
  assign out_res.level_6    = out_levels_r[6];
  assign out_res.strongest  = out_strongest_r;
  assign out_res.mean_level = out_mean_r;

endmodule
